// ----- src/hpt_pkg.sv -----
// shared types and constants of the hashed permission table
package hpt_pkg;

    localparam int KEY_W    = 32;
    localparam int CODE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int DIV_CNT_W = 2;
    localparam int ENTRY_W  = 1 + KEY_W + CODE_W;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_DELETE = 2'd3
    } kind_t;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // one stored way
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] code;
    } entry_t;

endpackage

// ----- src/hashed_permission_table_core.sv -----
// top level of the hashed permission table: sequencer, way scan and result register
//
// A set-associative table of 8-bit permission codes keyed by a 32-bit id.
// Each item is one operation (insert, update, search, delete) and gives
// exactly one result item (status and code). The bucket is key mod BUCKETS;
// every bucket holds WAYS ways, kept in one RAM of BUCKETS*WAYS entries.
// One item is handled at a time: after the accept cycle the ways of the
// bucket are read one per cycle from the single RAM read port and checked
// by one shared key comparator, stopping at the first match, and a final
// step, which waits for a full result register to drain, writes back and
// loads the result register. The next item can be accepted in the cycle
// after the result register loads. With BUCKETS a power of two the bucket
// index is the low key bits; otherwise it comes from a reciprocal multiply
// (multiply-high, quotient, remainder) before the way scan. s_ready is high
// only between items. After reset the block runs a clearing pass over all
// BUCKETS*WAYS entries (1024 at the defaults) with s_ready low; the config
// port takes writes at any time and holds the initial code given to new
// entries. A finished result waits in the output register while the next
// item is accepted.
module hashed_permission_table_core #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hpt_pkg::CODE_W-1:0]    cfg_data,
    // request items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hpt_pkg::KIND_W-1:0]    s_kind,
    input  logic [hpt_pkg::KEY_W-1:0]     s_key,
    input  logic [hpt_pkg::CODE_W-1:0]    s_new_code,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hpt_pkg::STATUS_W-1:0]  m_status,
    output logic [hpt_pkg::CODE_W-1:0]    m_code_out
);

    import hpt_pkg::*;

    localparam int DEPTH   = BUCKETS * WAYS;
    localparam int AW      = $clog2(DEPTH);
    localparam int BW      = $clog2(BUCKETS);
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    // scaled reciprocal of BUCKETS for the quotient of a 32-bit key
    localparam logic [KEY_W-1:0] RECIP =
        KEY_W'((64'd1 << KEY_W) * 64'((2 ** BW) - BUCKETS) / 64'(BUCKETS) + 64'd1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CMP   = 6'b010000,
        ST_ACT   = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [CODE_W-1:0]      initial_code_reg, initial_code_next;

    // item being worked on
    kind_t                  kind_reg, kind_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [CODE_W-1:0]      new_code_reg, new_code_next;
    logic [KEY_W-1:0]       shift_reg, shift_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [BW-1:0]          bucket_reg, bucket_next;
    logic [WW-1:0]          way_reg, way_next;
    logic [WW-1:0]          target_way_reg, target_way_next;
    logic                   hit_reg, hit_next;
    logic                   free_found_reg, free_found_next;
    logic [CODE_W-1:0]      code_reg, code_next;

    // result register
    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;
    logic [CODE_W-1:0]      m_code_out_reg, m_code_out_next;

    // ram ports
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    entry_t                 wr_entry;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [ENTRY_W-1:0]     rd_data;
    entry_t                 rd_entry;

    logic [AW-1:0]          base;
    logic [2*KEY_W-1:0]     recip_prod;
    logic [KEY_W-1:0]       quot;
    logic [BW-1:0]          quot_mul_low;
    logic                   out_free;
    logic                   s_fire;

    hpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry  = entry_t'(rd_data);
    assign base      = AW'(bucket_reg) * AW'(WAYS);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    // key mod BUCKETS: multiply-high, fix-up shift, then key minus quotient times BUCKETS
    assign recip_prod   = (2*KEY_W)'(RECIP) * (2*KEY_W)'(key_reg);
    assign quot         = (shift_reg + ((key_reg - shift_reg) >> 1)) >> (BW - 1);
    assign quot_mul_low = BW'(shift_reg[BW-1:0] * BW'(BUCKETS));

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_code_out = m_code_out_reg;

    always_comb begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        initial_code_next = initial_code_reg;
        kind_next         = kind_reg;
        key_next          = key_reg;
        new_code_next     = new_code_reg;
        shift_next        = shift_reg;
        div_cnt_next      = div_cnt_reg;
        bucket_next       = bucket_reg;
        way_next          = way_reg;
        target_way_next   = target_way_reg;
        hit_next          = hit_reg;
        free_found_next   = free_found_reg;
        code_next         = code_reg;
        m_valid_next      = m_valid_reg;
        m_status_next     = m_status_reg;
        m_code_out_next   = m_code_out_reg;

        wr_en    = 1'b0;
        wr_addr  = base + AW'(target_way_reg);
        wr_entry = '0;
        rd_en    = 1'b0;
        rd_addr  = base;

        if (cfg_valid) begin
            initial_code_next = cfg_data;
        end

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                // zero one entry per cycle after reset
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_entry = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next       = kind_t'(s_kind);
                    key_next        = s_key;
                    new_code_next   = s_new_code;
                    shift_next      = s_key;
                    div_cnt_next    = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    target_way_next = '0;
                    if (IS_POW2) begin
                        bucket_next = s_key[BW-1:0];
                        state_next  = ST_READ;
                    end else begin
                        bucket_next = '0;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                unique case (div_cnt_reg)
                    DIV_CNT_W'(0): begin
                        // high half of key times the reciprocal
                        shift_next = recip_prod[2*KEY_W-1:KEY_W];
                    end
                    DIV_CNT_W'(1): begin
                        // quotient
                        shift_next = quot;
                    end
                    default: begin
                        // remainder fits in the low bucket bits
                        bucket_next = key_reg[BW-1:0] - quot_mul_low;
                        state_next  = ST_READ;
                    end
                endcase
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            ST_READ: begin
                // fetch way zero
                rd_en      = 1'b1;
                rd_addr    = base;
                way_next   = '0;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // check the way on the read port, fetch the next one
                rd_en   = (way_reg != WW'(WAYS - 1));
                rd_addr = AW'(base + AW'(way_reg) + 1'b1);
                if (rd_entry.valid && (rd_entry.key == key_reg)) begin
                    hit_next        = 1'b1;
                    target_way_next = way_reg;
                    code_next       = rd_entry.code;
                    state_next      = ST_ACT;
                end else begin
                    if (!rd_entry.valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        target_way_next = way_reg;
                    end
                    if (way_reg == WW'(WAYS - 1)) begin
                        state_next = ST_ACT;
                    end else begin
                        way_next = way_reg + 1'b1;
                    end
                end
            end
            ST_ACT: begin
                // write back and post the result once the output is free
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = STATUS_OK;
                    m_code_out_next = '0;
                    unique case (kind_reg)
                        KIND_INSERT: begin
                            wr_entry.valid = 1'b1;
                            wr_entry.key   = key_reg;
                            wr_entry.code  = initial_code_reg;
                            if (hit_reg || free_found_reg) begin
                                wr_en = 1'b1;
                            end else begin
                                m_status_next = STATUS_FULL;
                            end
                        end
                        KIND_UPDATE: begin
                            wr_entry.valid = 1'b1;
                            wr_entry.key   = key_reg;
                            wr_entry.code  = new_code_reg;
                            if (hit_reg) begin
                                wr_en = 1'b1;
                            end else begin
                                m_status_next = STATUS_NOT_FOUND;
                            end
                        end
                        KIND_SEARCH: begin
                            if (hit_reg) begin
                                m_code_out_next = code_reg;
                            end else begin
                                m_status_next = STATUS_NOT_FOUND;
                            end
                        end
                        KIND_DELETE: begin
                            wr_entry = '0;
                            if (hit_reg) begin
                                wr_en = 1'b1;
                            end else begin
                                m_status_next = STATUS_NOT_FOUND;
                            end
                        end
                        default: begin
                            m_status_next = STATUS_NOT_FOUND;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            initial_code_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            initial_code_reg <= initial_code_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        new_code_reg   <= new_code_next;
        shift_reg      <= shift_next;
        div_cnt_reg    <= div_cnt_next;
        bucket_reg     <= bucket_next;
        way_reg        <= way_next;
        target_way_reg <= target_way_next;
        hit_reg        <= hit_next;
        free_found_reg <= free_found_next;
        code_reg       <= code_next;
        m_status_reg   <= m_status_next;
        m_code_out_reg <= m_code_out_next;
    end

endmodule

// ----- src/hpt_ram.sv -----
// generic simple dual-port ram with registered read
module hpt_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
